>>> hw/rtl/yuv420_block_to_rgb_core_macros.svh
// Assertion helpers for the block-to-RGB core.
// All macros sample on the rising edge of clock.
`ifndef YUV420_BLOCK_TO_RGB_CORE_MACROS_SVH
`define YUV420_BLOCK_TO_RGB_CORE_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define YB2R_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define YB2R_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Plain check, active through reset as well.
`define YB2R_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) (expr)) else $error(msg);

`endif

>>> hw/rtl/yb2r_pkg.sv
`timescale 1ns / 1ps

package yb2r_pkg;

   // Geometry of one block and of the fixed-point datapath
   localparam int LANES      = 4;
   localparam int PIX_W      = 8;
   localparam int COEF_W     = 18;
   localparam int PROD_W     = 27;   // 19-bit signed coef times 8-bit signed chroma
   localparam int TERM_W     = 28;   // room for the sum of the two green products
   localparam int SUM_W      = 30;   // luma in Q.16 plus any term plus rounding
   localparam int FRAC_BITS  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 6 * PIX_W;
   localparam int RSP_DATA_W = LANES * 3 * PIX_W;

   // Round-half-up offset in Q.16
   localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1 << (FRAC_BITS - 1));

   // BT.601 full-range gains, Q2.16
   localparam logic [COEF_W-1:0] COEF_RED_CR_RESET   = COEF_W'(91881);
   localparam logic [COEF_W-1:0] COEF_GREEN_CB_RESET = COEF_W'(22553);
   localparam logic [COEF_W-1:0] COEF_GREEN_CR_RESET = COEF_W'(46802);
   localparam logic [COEF_W-1:0] COEF_BLUE_CB_RESET  = COEF_W'(116130);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RED_CR   = 2'd0,
      CSR_GREEN_CB = 2'd1,
      CSR_GREEN_CR = 2'd2,
      CSR_BLUE_CB  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [COEF_W-1:0] blue_cb;
      logic [COEF_W-1:0] green_cr;
      logic [COEF_W-1:0] green_cb;
      logic [COEF_W-1:0] red_cr;
   } coef_set_type;

   // Chroma contributions shared by all four pixels, Q.16 signed
   typedef struct packed {
      logic signed [TERM_W-1:0] blue;
      logic signed [TERM_W-1:0] green;
      logic signed [TERM_W-1:0] red;
   } chroma_terms_type;

   // Red sits in the low byte so a pixel drops straight into tdata
   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } rgb_type;

   // Take a rounded Q.16 sum down to a byte, saturating at 0 and 255
   function automatic logic [PIX_W-1:0] sat_pixel(input logic signed [SUM_W-1:0] sum);
      logic [PIX_W-1:0] res;
      if (sum[SUM_W-1]) begin
         res = '0;
      end else if (|sum[SUM_W-2:FRAC_BITS+PIX_W]) begin
         res = '1;
      end else begin
         res = sum[FRAC_BITS+PIX_W-1:FRAC_BITS];
      end
      return res;
   endfunction

endpackage

>>> hw/rtl/yb2r_chroma.sv
`timescale 1ns / 1ps

// Shared chroma stage: four gain products, green pair summed, registered.
module yb2r_chroma (
   input  logic                          clock,
   input  logic                          en,
   input  logic [yb2r_pkg::PIX_W-1:0]    chroma_blue,
   input  logic [yb2r_pkg::PIX_W-1:0]    chroma_red,
   input  yb2r_pkg::coef_set_type        coefs,
   output yb2r_pkg::chroma_terms_type    terms_ff
);
   import yb2r_pkg::*;

   logic signed [PIX_W-1:0]  cb_s;
   logic signed [PIX_W-1:0]  cr_s;
   logic signed [PROD_W-1:0] red_prod;
   logic signed [PROD_W-1:0] gcb_prod;
   logic signed [PROD_W-1:0] gcr_prod;
   logic signed [PROD_W-1:0] blue_prod;
   chroma_terms_type         terms_in;

   // Removing the 128 offset is just flipping the top bit
   assign cb_s = $signed({~chroma_blue[PIX_W-1], chroma_blue[PIX_W-2:0]});
   assign cr_s = $signed({~chroma_red[PIX_W-1], chroma_red[PIX_W-2:0]});

   assign red_prod  = $signed({1'b0, coefs.red_cr})   * cr_s;
   assign gcb_prod  = $signed({1'b0, coefs.green_cb}) * cb_s;
   assign gcr_prod  = $signed({1'b0, coefs.green_cr}) * cr_s;
   assign blue_prod = $signed({1'b0, coefs.blue_cb})  * cb_s;

   always_comb begin
      terms_in.red   = TERM_W'(red_prod);
      terms_in.green = TERM_W'(gcb_prod) + TERM_W'(gcr_prod);
      terms_in.blue  = TERM_W'(blue_prod);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         terms_ff <= terms_in;
      end
   end

endmodule

>>> hw/rtl/yb2r_lane.sv
`timescale 1ns / 1ps

// One pixel lane: luma plus the shared chroma terms, rounded and clamped.
module yb2r_lane (
   input  logic                          clock,
   input  logic                          en,
   input  logic [yb2r_pkg::PIX_W-1:0]    luma,
   input  yb2r_pkg::chroma_terms_type    terms,
   output yb2r_pkg::rgb_type             pixel_ff
);
   import yb2r_pkg::*;

   logic signed [SUM_W-1:0] luma_q;
   logic signed [SUM_W-1:0] red_sum;
   logic signed [SUM_W-1:0] green_sum;
   logic signed [SUM_W-1:0] blue_sum;
   rgb_type                 pixel_in;

   // Luma in Q.16, never negative
   assign luma_q = $signed({{(SUM_W-PIX_W-FRAC_BITS){1'b0}}, luma, {FRAC_BITS{1'b0}}});

   assign red_sum   = luma_q + SUM_W'(terms.red)   + HALF_LSB;
   assign green_sum = luma_q - SUM_W'(terms.green) + HALF_LSB;
   assign blue_sum  = luma_q + SUM_W'(terms.blue)  + HALF_LSB;

   always_comb begin
      pixel_in.red   = sat_pixel(red_sum);
      pixel_in.green = sat_pixel(green_sum);
      pixel_in.blue  = sat_pixel(blue_sum);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pixel_ff <= pixel_in;
      end
   end

endmodule

>>> hw/rtl/yuv420_block_to_rgb_core.sv
`timescale 1ns / 1ps
`include "yuv420_block_to_rgb_core_macros.svh"
// 4:2:0 block to RGB converter, BT.601 full range.
// req_*: one word per 2x2 block, four luma bytes then Cb and Cr.
// rsp_*: one word per block, four RGB pixels (TL, TR, BL, BR), R lowest.
// csr_*: gain registers, Q2.16, written only while the core is idle;
// the user must keep to that, the core does not enforce it. Throughput is
// one block per clock while rsp_tready is not stalled: the chroma
// multipliers form stage one, the four pixel lanes stage two.
// Each stage holds its word while the next one is full, so the core keeps
// taking input as long as one stage is free; a stalled rsp_tready backs
// up through both stages, then drops req_tready.
// Reset (synchronous) empties both stages and loads the BT.601 gains.
module yuv420_block_to_rgb_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
   // chroma_blue, chroma_red
   input  logic [yb2r_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // red/green/blue of top_left, top_right, bottom_left, bottom_right
   output logic [yb2r_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [yb2r_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [yb2r_pkg::COEF_W-1:0]         csr_wdata
);
   import yb2r_pkg::*;

   // Full gain set as loaded by reset
   localparam coef_set_type GAINS_AT_RESET = '{
      blue_cb:  COEF_BLUE_CB_RESET,
      green_cr: COEF_GREEN_CR_RESET,
      green_cb: COEF_GREEN_CB_RESET,
      red_cr:   COEF_RED_CR_RESET
   };

   coef_set_type     coefs_ff;
   coef_set_type     coefs_in;
   logic             s1_valid_ff, s1_valid_in;
   logic             s2_valid_ff, s2_valid_in;
   logic             s1_adv, s2_adv;
   logic [PIX_W-1:0] luma_ff [LANES];
   chroma_terms_type terms;
   rgb_type          pixels [LANES];

   // Gain registers
   always_comb begin
      coefs_in = coefs_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_RED_CR:   coefs_in.red_cr   = csr_wdata;
            CSR_GREEN_CB: coefs_in.green_cb = csr_wdata;
            CSR_GREEN_CR: coefs_in.green_cr = csr_wdata;
            CSR_BLUE_CB:  coefs_in.blue_cb  = csr_wdata;
         endcase
      end
   end

   // Stage control: a stage moves when it is empty or its successor moves
   assign s2_adv      = !s2_valid_ff || rsp_tready;
   assign s1_adv      = !s1_valid_ff || s2_adv;
   assign req_tready  = s1_adv;
   assign s1_valid_in = s1_adv ? req_tvalid : s1_valid_ff;
   assign s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         s2_valid_ff       <= 1'b0;
         coefs_ff.red_cr   <= COEF_RED_CR_RESET;
         coefs_ff.green_cb <= COEF_GREEN_CB_RESET;
         coefs_ff.green_cr <= COEF_GREEN_CR_RESET;
         coefs_ff.blue_cb  <= COEF_BLUE_CB_RESET;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         coefs_ff    <= coefs_in;
      end
   end

   // Luma rides along with the chroma stage
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         for (int i = 0; i < LANES; i++) begin
            luma_ff[i] <= req_tdata[i*PIX_W +: PIX_W];
         end
      end
   end

   yb2r_chroma u_chroma (
      .clock       (clock),
      .en          (s1_adv),
      .chroma_blue (req_tdata[LANES*PIX_W +: PIX_W]),
      .chroma_red  (req_tdata[(LANES+1)*PIX_W +: PIX_W]),
      .coefs       (coefs_ff),
      .terms_ff    (terms)
   );

   // Pixel lanes, merged into the response word
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      yb2r_lane u_lane (
         .clock    (clock),
         .en       (s2_adv),
         .luma     (luma_ff[g]),
         .terms    (terms),
         .pixel_ff (pixels[g])
      );
      assign rsp_tdata[g*3*PIX_W +: 3*PIX_W] = pixels[g];
   end

   assign rsp_tvalid = s2_valid_ff;

   // Checks
   `YB2R_ASSERT_NEXT(a_accept_fills_s1, req_tvalid && req_tready, s1_valid_ff, "accepted word lost")
   `YB2R_ASSERT_NEXT(a_s1_moves_to_out, s1_valid_ff && s2_adv, rsp_tvalid, "stage one word stuck")
   `YB2R_ASSERT_NOW(a_empty_is_ready, !s1_valid_ff && !s2_valid_ff, req_tready, "empty, not ready")
   `YB2R_ASSERT_ALWAYS(a_reset_gains, !$fell(reset) || coefs_ff == GAINS_AT_RESET, "bad reset gains")

endmodule
